@@ rtl/sleep_wake_duty_controller_top_macros.svh @@
// Assertion macros used by the checker file.
// Each expands to one labeled concurrent assertion clocked on clk and
// disabled while rst is high.
`ifndef SLEEP_WAKE_DUTY_CONTROLLER_TOP_MACROS_SVH
`define SLEEP_WAKE_DUTY_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication
`define SWDC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swdc assertion failed");

// Next-cycle implication
`define SWDC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swdc assertion failed");

`endif

@@ rtl/swdc_pkg.sv @@
`timescale 1ns / 1ps

package swdc_pkg;

  // Field widths
  localparam int TimeW   = 32;
  localparam int CfgW    = 16;
  localparam int CfgSecW = 22;  // 65535 minutes in seconds fits in 22 bits
  localparam int CountW  = 6;

  localparam logic [CfgSecW-1:0] SecPerMin   = CfgSecW'(60);
  localparam logic [TimeW-1:0]   FaultAgeSec = TimeW'(30 * 60);
  localparam logic [CountW-1:0]  UpdateLimit = CountW'(33);

  // Configuration register indexes
  localparam logic [1:0] REG_ONLINE_MIN  = 2'd0;
  localparam logic [1:0] REG_SLEEP_MIN   = 2'd1;
  localparam logic [1:0] REG_SCAN_MIN    = 2'd2;
  localparam logic [1:0] REG_SAMPLE_WAIT = 2'd3;

  // Device status codes
  localparam logic [1:0] STATUS_SLEPT = 2'd0;
  localparam logic [1:0] STATUS_WOKE  = 2'd1;

  // Device commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_SLEEP = 2'd1;
  localparam logic [1:0] CMD_WAKE  = 2'd2;

  // Modes
  localparam logic MODE_WAKE  = 1'b0;
  localparam logic MODE_SLEEP = 1'b1;

  // Configuration, intervals already scaled to seconds
  typedef struct packed {
    logic [CfgSecW-1:0] online_sec;
    logic [CfgSecW-1:0] sleep_sec;
    logic [CfgSecW-1:0] scan_sec;
    logic [CfgW-1:0]    wait_sec;
  } cfg_t;

  // One poll word
  typedef struct packed {
    logic [TimeW-1:0] now_seconds;
    logic             status_valid;
    logic [1:0]       status_code;
    logic [TimeW-1:0] net_fault_since;
    logic             net_fault_flagged;
    logic [TimeW-1:0] reply_fault_since;
    logic             reply_fault_flagged;
    logic             update_active;
  } poll_t;

  // One result word
  typedef struct packed {
    logic       mode;
    logic       sample_request;
    logic [1:0] device_command;
    logic       net_fault_report;
    logic       reply_fault_report;
    logic       update_cancel;
  } result_t;

endpackage

@@ rtl/sleep_wake_duty_controller_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Word
// in        in_valid / in_ready   one poll: time, status, faults, update flag
// out       out_valid / out_ready one result: mode, sample, command, reports
// cfg       cfg_valid / cfg_ready register index and 16-bit data
//
// A poll lands in the input register, is evaluated combinationally and lands in
// the result register; one poll per cycle is sustained while out_ready stays high.
// The state update of one poll feeds the evaluation of the next directly.
// Synchronous reset clears the controller state, config and both valid flags.
// A stalled result holds the result register; the input register still takes
// one more poll before in_ready drops. cfg_ready is always high.

module sleep_wake_duty_controller_top
  import swdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic [TimeW-1:0] now_seconds,
  input  logic             status_valid,
  input  logic [1:0]       status_code,
  input  logic [TimeW-1:0] net_fault_since,
  input  logic             net_fault_flagged,
  input  logic [TimeW-1:0] reply_fault_since,
  input  logic             reply_fault_flagged,
  input  logic             update_active,

  output logic             out_valid,
  input  logic             out_ready,
  output logic             mode,
  output logic             sample_request,
  output logic [1:0]       device_command,
  output logic             net_fault_report,
  output logic             reply_fault_report,
  output logic             update_cancel,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CfgW-1:0]  cfg_data
);

  cfg_t    cfg;
  poll_t   poll_q;
  logic    poll_valid;
  result_t result;
  result_t result_q;
  logic    advance;

  assign cfg_ready = 1'b1;

  swdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline control
  assign advance  = poll_valid && (!out_valid || out_ready);
  assign in_ready = !poll_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_ready) begin
      poll_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      poll_q <= '{now_seconds:         now_seconds,
                  status_valid:        status_valid,
                  status_code:         status_code,
                  net_fault_since:     net_fault_since,
                  net_fault_flagged:   net_fault_flagged,
                  reply_fault_since:   reply_fault_since,
                  reply_fault_flagged: reply_fault_flagged,
                  update_active:       update_active};
    end
  end

  swdc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .poll    (poll_q),
    .advance (advance),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign mode               = result_q.mode;
  assign sample_request     = result_q.sample_request;
  assign device_command     = result_q.device_command;
  assign net_fault_report   = result_q.net_fault_report;
  assign reply_fault_report = result_q.reply_fault_report;
  assign update_cancel      = result_q.update_cancel;

endmodule

@@ rtl/swdc_cfg.sv @@
`timescale 1ns / 1ps

module swdc_cfg
  import swdc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output cfg_t            cfg
);

  logic [CfgSecW-1:0] data_sec;

  // minutes to seconds on the way in
  assign data_sec = CfgSecW'(cfg_data) * SecPerMin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ONLINE_MIN:  cfg.online_sec <= data_sec;
        REG_SLEEP_MIN:   cfg.sleep_sec  <= data_sec;
        REG_SCAN_MIN:    cfg.scan_sec   <= data_sec;
        REG_SAMPLE_WAIT: cfg.wait_sec   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/swdc_step.sv @@
`timescale 1ns / 1ps

module swdc_step
  import swdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  poll_t   poll,
  input  logic    advance,
  output result_t result
);

  // controller state
  logic              sleeping;
  logic              started;
  logic [TimeW-1:0]  interval_start;
  logic [TimeW-1:0]  last_sample_time;
  logic [CountW-1:0] update_wait_count;

  logic              sleeping_next;
  logic [TimeW-1:0]  interval_start_next;
  logic [TimeW-1:0]  last_sample_time_next;
  logic [CountW-1:0] update_wait_count_next;

  logic [CfgSecW-1:0] delay;
  logic [CfgSecW-1:0] first_gap;
  logic [TimeW-1:0]   start_eff;
  logic [TimeW-1:0]   last_eff;
  logic [TimeW-1:0]   elapsed;
  logic [TimeW-1:0]   since_sample;
  logic [TimeW-1:0]   net_age;
  logic [TimeW-1:0]   reply_age;
  logic [CountW-1:0]  count_inc;
  logic               msg_slept;
  logic               msg_woke;
  logic               online_done;
  logic               sleep_done;
  logic               sample;

  // first poll: interval starts now, first sample pulled in by the wait
  assign delay     = (CfgSecW'(cfg.wait_sec) > cfg.scan_sec) ? cfg.scan_sec
                                                             : CfgSecW'(cfg.wait_sec);
  assign first_gap = cfg.scan_sec - delay;
  assign start_eff = started ? interval_start : poll.now_seconds;
  assign last_eff  = started ? last_sample_time
                             : poll.now_seconds - TimeW'(first_gap);

  // elapsed/60 >= m is the same as elapsed >= 60*m
  assign elapsed      = poll.now_seconds - start_eff;
  assign since_sample = poll.now_seconds - last_eff;
  assign online_done  = elapsed >= TimeW'(cfg.online_sec);
  assign sleep_done   = elapsed >= TimeW'(cfg.sleep_sec);
  assign sample       = since_sample >= TimeW'(cfg.scan_sec);

  assign msg_slept = poll.status_valid && (poll.status_code == STATUS_SLEPT);
  assign msg_woke  = poll.status_valid && (poll.status_code == STATUS_WOKE);
  assign count_inc = update_wait_count + CountW'(1);

  // fault aging
  assign net_age   = poll.now_seconds - poll.net_fault_since;
  assign reply_age = poll.now_seconds - poll.reply_fault_since;

  // mode sequencing
  always_comb begin
    sleeping_next          = sleeping;
    interval_start_next    = start_eff;
    update_wait_count_next = update_wait_count;
    last_sample_time_next  = sample ? poll.now_seconds : last_eff;
    result.device_command  = CMD_NONE;
    result.update_cancel   = 1'b0;

    if (sleeping == MODE_WAKE) begin
      priority if (msg_slept) begin
        sleeping_next       = MODE_SLEEP;
        interval_start_next = poll.now_seconds;
      end else if (msg_woke) begin
        interval_start_next = poll.now_seconds;
      end else if (online_done) begin
        if (poll.update_active) begin
          // count expired polls, give up on the update past the limit
          if (count_inc > UpdateLimit) begin
            result.update_cancel   = 1'b1;
            update_wait_count_next = '0;
          end else begin
            update_wait_count_next = count_inc;
          end
        end else begin
          result.device_command = CMD_SLEEP;
        end
      end else begin
        // still within the online time
      end
    end else begin
      priority if (msg_woke) begin
        sleeping_next       = MODE_WAKE;
        interval_start_next = poll.now_seconds;
      end else if (msg_slept) begin
        interval_start_next = poll.now_seconds;
      end else if (sleep_done) begin
        result.device_command = CMD_WAKE;
      end else begin
        // still within the sleep time
      end
    end

    result.mode               = sleeping_next;
    result.sample_request     = sample;
    result.net_fault_report   = (poll.net_fault_since != '0) && !poll.net_fault_flagged
                                && (net_age >= FaultAgeSec);
    result.reply_fault_report = (poll.reply_fault_since != '0) && !poll.reply_fault_flagged
                                && (reply_age >= FaultAgeSec);
  end

  // state update, one poll per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      sleeping          <= MODE_WAKE;
      started           <= 1'b0;
      interval_start    <= '0;
      last_sample_time  <= '0;
      update_wait_count <= '0;
    end else if (advance) begin
      sleeping          <= sleeping_next;
      started           <= 1'b1;
      interval_start    <= interval_start_next;
      last_sample_time  <= last_sample_time_next;
      update_wait_count <= update_wait_count_next;
    end
  end

endmodule

@@ rtl/swdc_checker.sv @@
`timescale 1ns / 1ps
`include "sleep_wake_duty_controller_top_macros.svh"

module swdc_checker
  import swdc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       mode,
  input logic       sample_request,
  input logic [1:0] device_command,
  input logic       net_fault_report,
  input logic       reply_fault_report,
  input logic       update_cancel
);

  // a stalled result word holds
  `SWDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(sample_request) && $stable(device_command) && $stable(update_cancel) && $stable(net_fault_report) && $stable(reply_fault_report))

  // a sleep command only goes out while the device stays awake
  `SWDC_ASSERT_NOW(a_sleep_cmd_awake, out_valid && device_command == CMD_SLEEP, mode == MODE_WAKE)

  // a wake command only goes out while the device stays asleep
  `SWDC_ASSERT_NOW(a_wake_cmd_asleep, out_valid && device_command == CMD_WAKE, mode == MODE_SLEEP)

  // a cancel replaces the sleep command and only happens awake
  `SWDC_ASSERT_NOW(a_cancel_alone, out_valid && update_cancel, device_command == CMD_NONE && mode == MODE_WAKE)

endmodule

bind sleep_wake_duty_controller_top swdc_checker u_swdc_checker (.*);
